[design/tbsp_pkg.sv]
`timescale 1ns / 1ps
package tbsp_pkg;

    localparam logic [2:0] KIND_DIST  = 3'd0;
    localparam logic [2:0] KIND_TOUR  = 3'd1;
    localparam logic [2:0] KIND_COST  = 3'd2;
    localparam logic [2:0] KIND_PERT  = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_POS = 2'd2;
    localparam logic [1:0] ST_OVERLAP = 2'd3;

    localparam int unsigned PW = 12;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] a;
        logic [5:0] la;
        logic [8:0] b;
        logic [5:0] lb;
        logic       adj;
    } t_chk;

endpackage

[design/tbsp_check.sv]
`timescale 1ns / 1ps
module tbsp_check import tbsp_pkg::*; (
    input  logic       i_clk,
    input  logic [9:0] i_len,
    input  logic [8:0] i_fs,
    input  logic [5:0] i_fl,
    input  logic [8:0] i_ss,
    input  logic [5:0] i_sl,
    output t_chk       o_chk
);

    logic [8:0]  a, b;
    logic [5:0]  la, lb;
    logic [17:0] prod;
    logic [6:0]  qmax;
    logic        len_bad, pos_bad, ovl;
    logic [1:0]  status;
    t_chk        r_chk;

    always_comb begin
        if (i_ss < i_fs) begin
            a = i_ss; la = i_sl; b = i_fs; lb = i_fl;
        end else begin
            a = i_fs; la = i_fl; b = i_ss; lb = i_sl;
        end
        prod    = 18'(i_len) * 18'd205;
        qmax    = prod[17:11];
        len_bad = (la < 6'd2) || ({1'b0, la} > qmax) || (lb < 6'd2) || ({1'b0, lb} > qmax);
        pos_bad = (a == 9'd0) || (b == 9'd0)
               || ((11'(a) + 11'(la) + 11'd2) > 11'(i_len))
               || ((11'(b) + 11'(lb) + 11'd2) > 11'(i_len));
        ovl     = (a == b) || ((10'(a) + 10'(la)) > 10'(b));
        priority if (len_bad) status = ST_BAD_LEN;
        else if (pos_bad)     status = ST_BAD_POS;
        else if (ovl)         status = ST_OVERLAP;
        else                  status = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        r_chk.status <= status;
        r_chk.a      <= a;
        r_chk.la     <= la;
        r_chk.b      <= b;
        r_chk.lb     <= lb;
        r_chk.adj    <= ((10'(a) + 10'(la)) == 10'(b));
    end

    assign o_chk = r_chk;

endmodule

[design/tbsp_dist_ram.sv]
`timescale 1ns / 1ps
module tbsp_dist_ram #(
    parameter int unsigned AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [2**AW];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/tour_block_swap_perturb_core.sv]
`timescale 1ns / 1ps
// channel  | dir | tdata (low bit up)                                 | tuser
// s_axis   | in  | city_from, city_to, distance, position, tour_city, | kind
//          |     | cost_in, first_start, first_len, second_start,     |
//          |     | second_len, one zero pad bit                       |
// m_axis   | out | cost_change, cost_out, read_city                   | status
// i_cfg    | in  | tour_length                                        | -
// Load and read items go from S_EXEC straight to S_DONE; a rejected perturb
// passes S_CHK between them. An accepted perturb does 8 tour reads, 9 distance
// reads, then copies the span from the first block start to the end of the second
// into a scratch memory and back, one entry per cycle on the tour port.
// Reset clears control state and the cost; the memories keep their contents.
// A new item is taken once the previous one is in the output register; a
// stalled output holds the next result in its final state.
module tour_block_swap_perturb_core import tbsp_pkg::*; #(
    parameter int unsigned MAX_CITIES = 256,
    parameter int unsigned MAX_TOUR   = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [9:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,  // city_from, city_to, distance, position,
                                        // tour_city, cost_in, first_start, first_len,
                                        // second_start, second_len, pad
    input  logic [2:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // cost_change, cost_out, read_city
    output logic [1:0]   m_axis_tuser   // status
);

    localparam int unsigned CW = $clog2(MAX_CITIES);
    localparam int unsigned TW = $clog2(MAX_TOUR);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_CHK, S_TRD, S_DRD, S_P1, S_P2, S_DONE
    } t_state;

    t_state             r_state;
    logic [2:0]         r_kind;
    logic [7:0]         r_cf, r_ct, r_tc;
    logic [31:0]        r_dist;
    logic [8:0]         r_pos, r_fs, r_ss;
    logic [5:0]         r_fl, r_sl;
    logic signed [47:0] r_cin, r_cost, r_d;
    logic [9:0]         r_len;
    logic [1:0]         r_status;
    logic [PW-1:0]      r_cnt, r_total, r_pidx;
    logic               r_pv, r_pneg, r_pen;
    logic [7:0]         r_cty [8];
    logic               r_ov;
    logic [103:0]       r_odata;
    logic [1:0]         r_ouser;

    t_chk               c_chk;
    logic [9:0]         lim;
    logic [PW-1:0]      a12, la12, b12, lb12, off_b, dest, tsel, pos12;
    logic [PW-1:0]      rd_pos, wr_pos;
    logic               pos_ok, cf_ok, ct_ok;
    logic [7:0]         dfrom, dto;
    logic               dneg, den;
    logic               t_we, t_re, s_we, s_re, d_we, d_re;
    logic [TW-1:0]      t_waddr, t_raddr, s_waddr, s_raddr;
    logic [7:0]         t_wdata;
    logic [7:0]         r_trd, r_srd;
    logic [7:0]         r_tmem [MAX_TOUR];
    logic [7:0]         r_smem [MAX_TOUR];
    logic [31:0]        d_rdata;
    logic [PW-1:0]      cf12, ct12, df12, dt12;
    logic signed [48:0] sum;
    logic signed [47:0] cost_sat;
    logic               out_free;

    assign lim    = ({2'b0, r_len} > PW'(MAX_TOUR)) ? 10'(MAX_TOUR) : r_len;
    assign a12    = PW'(c_chk.a);
    assign la12   = PW'(c_chk.la);
    assign b12    = PW'(c_chk.b);
    assign lb12   = PW'(c_chk.lb);
    assign off_b  = b12 - a12;
    assign pos12  = PW'(r_pos);
    assign pos_ok = pos12 < PW'(MAX_TOUR);
    assign cf12   = PW'(r_cf);
    assign ct12   = PW'(r_ct);
    assign cf_ok  = cf12 < PW'(MAX_CITIES);
    assign ct_ok  = ct12 < PW'(MAX_CITIES);
    assign out_free = !r_ov || m_axis_tready;
    assign rd_pos = a12 + r_cnt;
    assign wr_pos = a12 + r_pidx;

    tbsp_check u_check (
        .i_clk (i_clk),
        .i_len (lim),
        .i_fs  (r_fs),
        .i_fl  (r_fl),
        .i_ss  (r_ss),
        .i_sl  (r_sl),
        .o_chk (c_chk)
    );

    always_comb begin
        unique case (r_cnt[2:0])
            3'd0:    tsel = a12;
            3'd1:    tsel = a12 - PW'(1);
            3'd2:    tsel = a12 + la12 - PW'(1);
            3'd3:    tsel = a12 + la12;
            3'd4:    tsel = b12;
            3'd5:    tsel = b12 - PW'(1);
            3'd6:    tsel = b12 + lb12 - PW'(1);
            default: tsel = b12 + lb12;
        endcase
        if (r_pidx < la12) begin
            dest = r_pidx + r_total - la12;
        end else if (r_pidx < off_b) begin
            dest = r_pidx - la12 + lb12;
        end else begin
            dest = r_pidx - off_b;
        end
    end

    // p=0 pp=1 ep=2 np=3 s=4 ps=5 es=6 ns=7
    always_comb begin
        dneg = 1'b0;
        den  = 1'b1;
        unique case (r_cnt[3:0])
            4'd0: begin dfrom = r_cty[1]; dto = r_cty[0]; dneg = 1'b1; end
            4'd1: begin dfrom = r_cty[1]; dto = r_cty[4]; end
            4'd2: begin dfrom = r_cty[2]; dto = r_cty[3]; dneg = 1'b1; den = !c_chk.adj; end
            4'd3: begin dfrom = r_cty[6]; dto = r_cty[3]; den = !c_chk.adj; end
            4'd4: begin dfrom = r_cty[5]; dto = r_cty[4]; dneg = 1'b1; end
            4'd5: begin dfrom = r_cty[5]; dto = r_cty[0]; den = !c_chk.adj; end
            4'd6: begin dfrom = r_cty[6]; dto = r_cty[7]; dneg = 1'b1; end
            4'd7: begin dfrom = r_cty[2]; dto = r_cty[7]; end
            default: begin dfrom = r_cty[6]; dto = r_cty[0]; den = c_chk.adj; end
        endcase
    end

    assign df12 = PW'(dfrom);
    assign dt12 = PW'(dto);

    always_comb begin
        t_we    = 1'b0;
        t_waddr = pos12[TW-1:0];
        t_wdata = r_tc;
        t_re    = 1'b0;
        t_raddr = pos12[TW-1:0];
        s_we    = 1'b0;
        s_re    = 1'b0;
        s_raddr = r_cnt[TW-1:0];
        s_waddr = dest[TW-1:0];
        d_we    = (r_state == S_EXEC) && (r_kind == KIND_DIST) && cf_ok && ct_ok;
        d_re    = (r_state == S_DRD) && (r_cnt < PW'(9));
        unique case (r_state)
            S_EXEC: begin
                t_we = (r_kind == KIND_TOUR) && pos_ok;
                t_re = (r_kind == KIND_READ) && pos_ok;
            end
            S_TRD: begin
                t_re    = r_cnt < PW'(8);
                t_raddr = tsel[TW-1:0];
            end
            S_P1: begin
                t_re    = r_cnt < r_total;
                t_raddr = rd_pos[TW-1:0];
                s_we    = r_pv;
            end
            S_P2: begin
                s_re    = r_cnt < r_total;
                t_we    = r_pv;
                t_waddr = wr_pos[TW-1:0];
                t_wdata = r_srd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[t_waddr] <= t_wdata;
        end
        if (t_re) begin
            r_trd <= r_tmem[t_raddr];
        end
        if (s_we) begin
            r_smem[s_waddr] <= r_trd;
        end
        if (s_re) begin
            r_srd <= r_smem[s_raddr];
        end
    end

    tbsp_dist_ram #(.AW(2 * CW)) u_dist (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr ({cf12[CW-1:0], ct12[CW-1:0]}),
        .i_wdata (r_dist),
        .i_re    (d_re),
        .i_raddr ({df12[CW-1:0], dt12[CW-1:0]}),
        .o_rdata (d_rdata)
    );

    assign sum      = 49'(r_cost) + 49'(r_d);
    assign cost_sat = (sum[48] != sum[47]) ? {sum[48], {47{~sum[48]}}} : sum[47:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= 10'd20;
            r_cost  <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (r_ov && m_axis_tready && !((r_state == S_DONE) && out_free)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind  <= s_axis_tuser;
                        r_cf    <= s_axis_tdata[7:0];
                        r_ct    <= s_axis_tdata[15:8];
                        r_dist  <= s_axis_tdata[47:16];
                        r_pos   <= s_axis_tdata[56:48];
                        r_tc    <= s_axis_tdata[64:57];
                        r_cin   <= s_axis_tdata[112:65];
                        r_fs    <= s_axis_tdata[121:113];
                        r_fl    <= s_axis_tdata[127:122];
                        r_ss    <= s_axis_tdata[136:128];
                        r_sl    <= s_axis_tdata[142:137];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= ST_OK;
                    r_d      <= '0;
                    if (r_kind == KIND_COST) begin
                        r_cost <= r_cin;
                    end
                    r_state <= (r_kind == KIND_PERT) ? S_CHK : S_DONE;
                end
                S_CHK: begin
                    r_status <= c_chk.status;
                    r_cnt    <= '0;
                    r_total  <= b12 + lb12 - a12;
                    r_state  <= (c_chk.status == ST_OK) ? S_TRD : S_DONE;
                end
                S_TRD: begin
                    r_pv   <= t_re;
                    r_pidx <= r_cnt;
                    if (r_pv) begin
                        r_cty[r_pidx[2:0]] <= r_trd;
                    end
                    if (t_re) begin
                        r_cnt <= r_cnt + PW'(1);
                    end else if (!r_pv) begin
                        r_cnt   <= '0;
                        r_state <= S_DRD;
                    end
                end
                S_DRD: begin
                    r_pv   <= d_re;
                    r_pneg <= dneg;
                    r_pen  <= den && (df12 < PW'(MAX_CITIES)) && (dt12 < PW'(MAX_CITIES));
                    if (r_pv && r_pen) begin
                        r_d <= r_pneg ? (r_d - 48'(d_rdata)) : (r_d + 48'(d_rdata));
                    end
                    if (d_re) begin
                        r_cnt <= r_cnt + PW'(1);
                    end else if (!r_pv) begin
                        r_cnt   <= '0;
                        r_state <= S_P1;
                    end
                end
                S_P1, S_P2: begin
                    r_pv   <= t_re || s_re;
                    r_pidx <= r_cnt;
                    if (r_cnt < r_total) begin
                        r_cnt <= r_cnt + PW'(1);
                    end else if (!r_pv) begin
                        r_cnt <= '0;
                        if (r_state == S_P1) begin
                            r_state <= S_P2;
                        end else begin
                            r_cost  <= cost_sat;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_ouser <= r_status;
                        r_odata <= {((r_kind == KIND_READ) && pos_ok) ? r_trd : 8'd0,
                                    r_cost, r_d};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    a_reject_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[47:0] == 48'd0))
        else $error("rejected perturb reports a cost change");

    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P1) || (r_state == S_P2) |-> (r_cnt <= r_total))
        else $error("span copy ran past the span");

    a_dist_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_re |-> (r_status == ST_OK) && (r_cnt < PW'(9)))
        else $error("distance read outside the cost phase");

    a_cost_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRD) || (r_state == S_DRD) || (r_state == S_P1) |=> $stable(r_cost))
        else $error("cost changed before the swap finished");

endmodule

[tb/sv/tb_tour_block_swap_perturb_core.sv]
`timescale 1ns / 1ps
module tb_tour_block_swap_perturb_core;
    import tbsp_pkg::*;

    localparam int NCITY = 256;
    localparam int NTOUR = 512;
    localparam longint SMAX = 64'sd140737488355327;
    localparam longint SMIN = -64'sd140737488355328;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  city_from;
        logic [7:0]  city_to;
        logic [31:0] distance;
        logic [8:0]  position;
        logic [7:0]  tour_city;
        logic [47:0] cost_in;
        logic [8:0]  first_start;
        logic [5:0]  first_len;
        logic [8:0]  second_start;
        logic [5:0]  second_len;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] cost_change;
        logic [47:0] cost_out;
        logic [7:0]  read_city;
    } result_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [9:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    tour_block_swap_perturb_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] dist_mem [NCITY*NCITY];
    logic [7:0]  tour_mem [NTOUR];
    longint      cost_q;
    int          tour_len_q;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      n_mismatch = 0;
    int      n_sent = 0;
    bit      quiet_mode = 1'b0;
    bit      hold_send = 1'b0;
    int      idle_cycles = 0;
    bit      stimulus_done = 1'b0;

    function automatic longint dget(int a, int b);
        return longint'(dist_mem[a*NCITY + b]);
    endfunction

    function automatic logic [1:0] block_status(int len, int st, int lim);
        if (len < 2 || len > lim / 10) return ST_BAD_LEN;
        if (st < 1 || st + len + 2 > lim) return ST_BAD_POS;
        return ST_OK;
    endfunction

    function automatic result_t apply_item(item_t it);
        result_t r;
        int lim, a, la, b, lb, t, k, p, pp, ep, np, s, ps, es, ns;
        logic [1:0] sa, sb;
        longint d;
        logic [7:0] span [NTOUR];
        r = '0;
        case (it.kind)
            KIND_DIST: dist_mem[it.city_from*NCITY + it.city_to] = it.distance;
            KIND_TOUR: tour_mem[it.position] = it.tour_city;
            KIND_COST: cost_q = longint'(signed'(it.cost_in));
            KIND_READ: r.read_city = tour_mem[it.position];
            KIND_PERT: begin
                lim = tour_len_q > NTOUR ? NTOUR : tour_len_q;
                a = it.first_start; la = it.first_len;
                b = it.second_start; lb = it.second_len;
                if (b < a) begin
                    t = a; a = b; b = t;
                    t = la; la = lb; lb = t;
                end
                sa = block_status(la, a, lim);
                sb = block_status(lb, b, lim);
                if (sa == ST_BAD_LEN || sb == ST_BAD_LEN) r.status = ST_BAD_LEN;
                else if (sa == ST_BAD_POS || sb == ST_BAD_POS) r.status = ST_BAD_POS;
                else if (a == b || a + la > b) r.status = ST_OVERLAP;
                else begin
                    p = tour_mem[a]; pp = tour_mem[a-1];
                    ep = tour_mem[a+la-1]; np = tour_mem[a+la];
                    s = tour_mem[b]; ps = tour_mem[b-1];
                    es = tour_mem[b+lb-1]; ns = tour_mem[b+lb];
                    d = -dget(pp, p) + dget(pp, s) - dget(ep, np) + dget(es, np)
                        - dget(ps, s) + dget(ps, p) - dget(es, ns) + dget(ep, ns);
                    if (a + la == b)
                        d += dget(es, p) + dget(ep, np) - dget(es, np) - dget(ps, p);
                    k = 0;
                    for (int i = 0; i < lb; i++) begin
                        span[k] = tour_mem[b+i];
                        k++;
                    end
                    for (int i = a + la; i < b; i++) begin
                        span[k] = tour_mem[i];
                        k++;
                    end
                    for (int i = 0; i < la; i++) begin
                        span[k] = tour_mem[a+i];
                        k++;
                    end
                    for (int i = 0; i < k; i++) tour_mem[a+i] = span[i];
                    cost_q = cost_q + d;
                    if (cost_q > SMAX) cost_q = SMAX;
                    if (cost_q < SMIN) cost_q = SMIN;
                    r.cost_change = d[47:0];
                end
            end
            default: ;
        endcase
        r.cost_out = cost_q[47:0];
        return r;
    endfunction

    function automatic logic [143:0] pack_item(item_t it);
        return {1'b0, it.second_len, it.second_start, it.first_len, it.first_start,
                it.cost_in, it.tour_city, it.position, it.distance,
                it.city_to, it.city_from};
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(apply_item(pending_items.pop_front()));
            n_sent++;
        end
        if (i_rst_n && !hold_send && pending_items.size() > 0 &&
                (quiet_mode || $urandom_range(99) >= 15)) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pack_item(pending_items[0]);
            s_axis_tuser  <= pending_items[0].kind;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        result_t got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[95:48],
                   m_axis_tdata[103:96]};
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.cost_change !== want.cost_change ||
                        got.cost_out !== want.cost_out || got.read_city !== want.read_city) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: st %0d/%0d chg %h/%h cost %h/%h city %h/%h",
                                 want.status, got.status, want.cost_change, got.cost_change,
                                 want.cost_out, got.cost_out, want.read_city, got.read_city);
                end
            end
        end
        m_axis_tready <= i_rst_n && (quiet_mode || $urandom_range(99) >= 15);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n
                || stimulus_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb_tour_block_swap_perturb_core: errors");
            $finish;
        end
    end

    int cur_len = 20;
    bit [NTOUR-1:0] written;

    function automatic item_t blank(logic [2:0] k);
        item_t it;
        it = '0;
        it.kind = k;
        return it;
    endfunction

    task automatic push_tour(int pos, int city);
        item_t it;
        it = blank(KIND_TOUR);
        it.position = 9'(pos);
        it.tour_city = 8'(city);
        pending_items.push_back(it);
        written[pos] = 1'b1;
    endtask

    task automatic push_perturb(int fs, int fl, int ss, int sl);
        item_t it;
        it = blank(KIND_PERT);
        it.first_start = 9'(fs); it.first_len = 6'(fl);
        it.second_start = 9'(ss); it.second_len = 6'(sl);
        it.cost_in = 48'({$urandom, $urandom});
        pending_items.push_back(it);
    endtask

    task automatic drain();
        wait (pending_items.size() == 0);
        while (expected_results.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_length(int len);
        drain();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 10'(len);
        tour_len_q = len;
        cur_len = len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // fill the tour so any perturb reads only written entries
        for (int i = 0; i < len && i < NTOUR; i++)
            if (!written[i]) push_tour(i, $urandom_range(15));
    endtask

    task automatic random_perturb();
        int lim, mx, fl, sl, fs, ss;
        lim = cur_len > NTOUR ? NTOUR : cur_len;
        mx = lim / 10;
        if (mx > 63) mx = 63;
        if ($urandom_range(99) < 75) begin
            fl = $urandom_range(mx, 2);
            sl = $urandom_range(mx, 2);
            fs = $urandom_range(lim - fl - sl - 4, 1);
            ss = ($urandom_range(3) == 0) ? fs + fl
                 : $urandom_range(lim - sl - 2, fs + fl);
            if ($urandom_range(1)) push_perturb(fs, fl, ss, sl);
            else push_perturb(ss, sl, fs, fl);
        end else begin
            push_perturb($urandom_range(511), $urandom_range(63),
                         $urandom_range(511), $urandom_range(63));
        end
    endtask

    task automatic random_item();
        item_t it;
        int r, pos;
        r = $urandom_range(99);
        it = blank(3'($urandom_range(7)));
        it.city_from = 8'($urandom); it.city_to = 8'($urandom); it.distance = $urandom;
        it.cost_in = 48'({$urandom, $urandom});
        if (r < 45) begin
            random_perturb();
            return;
        end else if (r < 60) begin
            it.kind = KIND_DIST;
            it.city_from = 8'($urandom_range(15)); it.city_to = 8'($urandom_range(15));
            if ($urandom_range(9) == 0) it.distance = $urandom;
            else it.distance = $urandom_range(100000);
        end else if (r < 70) begin
            // wide cities only in the last two positions; a perturb may read 510 but never 511
            pos = $urandom_range(511);
            push_tour(pos, (pos >= NTOUR - 2 && $urandom_range(1)) ? $urandom_range(255)
                                                                   : $urandom_range(15));
            return;
        end else if (r < 85) begin
            it.kind = KIND_READ;
            do it.position = 9'($urandom); while (!written[it.position]);
        end else if (r < 90) begin
            it.kind = KIND_COST;
        end else if (it.kind == KIND_PERT || it.kind == KIND_READ ||
                     it.kind == KIND_TOUR) begin
            it.kind = 3'd5 + 3'($urandom_range(2));
        end
        pending_items.push_back(it);
    endtask

    initial begin
        item_t it;
        foreach (dist_mem[i]) dist_mem[i] = '0;
        foreach (tour_mem[i]) tour_mem[i] = '0;
        cost_q = 0;
        tour_len_q = 20;
        written = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // distance matrix over 16 cities, extremes included
        for (int a = 0; a < 16; a++)
            for (int b = 0; b < 16; b++) begin
                it = blank(KIND_DIST);
                it.city_from = 8'(a); it.city_to = 8'(b);
                it.distance = (a == 1 && b == 2) ? 32'hFFFF_FFFF : $urandom_range(100000);
                pending_items.push_back(it);
            end
        it = blank(KIND_DIST);
        it.city_from = 8'hFF; it.city_to = 8'hFF; it.distance = 32'hFFFF_FFFF;
        pending_items.push_back(it);
        set_length(20);
        // directed
        push_perturb(2, 2, 10, 2);
        push_perturb(10, 2, 2, 2);
        push_perturb(2, 2, 4, 2);
        push_perturb(2, 1, 10, 2);
        push_perturb(2, 3, 10, 2);
        push_perturb(0, 2, 10, 2);
        push_perturb(2, 2, 16, 2);
        push_perturb(3, 2, 3, 2);
        push_perturb(3, 2, 4, 2);
        it = blank(KIND_COST); it.cost_in = 48'h7FFF_FFFF_FFF0; pending_items.push_back(it);
        push_perturb(2, 2, 10, 2);
        it = blank(KIND_COST); it.cost_in = 48'h8000_0000_0000; pending_items.push_back(it);
        push_perturb(2, 2, 10, 2);
        it = blank(KIND_READ); it.position = 9'd3; pending_items.push_back(it);
        it = blank(3'd7); pending_items.push_back(it);
        push_tour(511, 255);
        it = blank(KIND_READ); it.position = 9'd511; pending_items.push_back(it);
        // sender holds until everything is back
        wait (pending_items.size() == 0);
        hold_send = 1'b1;
        while (expected_results.size() != 0) @(posedge i_clk);
        hold_send = 1'b0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_length(20);
                1: set_length(100);
                2: set_length(1023);
                3: set_length(63);
                default: set_length(512);
            endcase
            quiet_mode = (ph == 2);
            for (int n = 0; n < 77; n++) random_item();
        end
        drain();
        stimulus_done = 1'b1;
        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("tb_tour_block_swap_perturb_core: clean");
        else
            $display("tb_tour_block_swap_perturb_core: errors");
        $finish;
    end

endmodule
